/* hdl/pgr_pkg.sv */
// Shared types and constants for the two-level page table pager.
// Used by every module under hdl/ but pgr_ram; depends on nothing.
package pgr_pkg;

   localparam int DIR_BITS     = 10;
   localparam int TAB_BITS     = 10;
   localparam int PAGE_BITS    = DIR_BITS + TAB_BITS;
   localparam int TAB_LSB      = 12;
   localparam int DIR_LSB      = TAB_LSB + TAB_BITS;
   localparam int ADDR_BITS    = 32;
   localparam int STAMP_BITS   = 32;
   localparam int FRAME_BITS   = 21;
   localparam int COST_BITS    = 16;
   localparam int STEP_BITS    = 18;
   localparam int COUNT_BITS   = 32;
   localparam int CSR_IDX_BITS = 2;
   localparam int CSR_DAT_BITS = 21;

   localparam logic [CSR_IDX_BITS-1:0] CSR_MAX_FRAMES   = 2'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_MEM_COST     = 2'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_PAGE_IN_COST = 2'd2;
   localparam logic [CSR_IDX_BITS-1:0] CSR_PAGE_OUT_COST = 2'd3;

   localparam logic [FRAME_BITS-1:0] MAX_FRAMES_RST   = 21'd16;
   localparam logic [COST_BITS-1:0]  MEM_COST_RST     = 16'd10;
   localparam logic [COST_BITS-1:0]  PAGE_IN_COST_RST = 16'd5000;
   localparam logic [COST_BITS-1:0]  PAGE_OUT_COST_RST = 16'd5000;

   typedef struct packed {
      logic                  alloc;
      logic                  present;
      logic                  dirty;
      logic [STAMP_BITS-1:0] stamp;
   } entry_type;

   localparam int ENTRY_BITS = $bits(entry_type);

   typedef struct packed {
      logic                 init;
      logic                 valid;
      logic [PAGE_BITS-1:0] idx;
   } scan_ctl_type;

   typedef struct packed {
      logic                 found;
      logic [PAGE_BITS-1:0] idx;
      entry_type            entry;
   } scan_res_type;

endpackage

/* hdl/two_level_page_table_lru_pager.sv */
// Top level of the two-level page table pager with LRU replacement.
// Depends on pgr_pkg, pgr_ram and pgr_scan.
//
// Usage:
//   An access (req_mode, req_address) transfers on a clock edge with start
//   high and busy low. Exactly one result comes back later on the rsp_ ports,
//   held for a single cycle and marked by rsp_valid; the receiver cannot
//   stall it. busy stays high until that result is out.
//   A hit passes through LOOK and FINISH; a fault with room in the working
//   set through LOOK, CHECK, PLACE and FINISH. A fault with a full working set
//   scans all 2^20 page entries through one shared stamp comparator, one
//   entry per cycle. Only one access is in flight at a time.
//   Registers are written through csr_wr_en / csr_index / csr_wdata at any
//   edge; write them only while busy is low and no result is pending.
//   Reset: synchronous, active high. Afterward a clearing pass zeroes the
//   directory and page memories, one entry per cycle over all 2^20 page
//   entries; busy is high during the pass.
module two_level_page_table_lru_pager (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   output logic                               busy,
   input  logic                               req_mode,
   input  logic [pgr_pkg::ADDR_BITS-1:0]      req_address,
   input  logic                               csr_wr_en,
   input  logic [pgr_pkg::CSR_IDX_BITS-1:0]   csr_index,
   input  logic [pgr_pkg::CSR_DAT_BITS-1:0]   csr_wdata,
   output logic                               rsp_valid,
   output logic                               rsp_table_allocated,
   output logic                               rsp_page_allocated,
   output logic                               rsp_page_swapped_in,
   output logic                               rsp_evicted,
   output logic [pgr_pkg::DIR_BITS-1:0]       rsp_victim_dir_index,
   output logic [pgr_pkg::TAB_BITS-1:0]       rsp_victim_table_index,
   output logic                               rsp_victim_dirty,
   output logic [pgr_pkg::STEP_BITS-1:0]      rsp_cycles_added,
   output logic [pgr_pkg::COUNT_BITS-1:0]     rsp_total_cycles,
   output logic [pgr_pkg::FRAME_BITS-1:0]     rsp_working_set,
   output logic [pgr_pkg::FRAME_BITS-1:0]     rsp_peak_working_set,
   output logic [pgr_pkg::COUNT_BITS-1:0]     rsp_access_count
);

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_CLEAR  = 3'd1;
   localparam logic [2:0] S_LOOK   = 3'd2;
   localparam logic [2:0] S_CHECK  = 3'd3;
   localparam logic [2:0] S_SCAN   = 3'd4;
   localparam logic [2:0] S_EVICT  = 3'd5;
   localparam logic [2:0] S_PLACE  = 3'd6;
   localparam logic [2:0] S_FINISH = 3'd7;

   logic [2:0] state_ff, state_in;

   // configuration
   logic [pgr_pkg::FRAME_BITS-1:0] max_frames_ff;
   logic [pgr_pkg::COST_BITS-1:0]  mem_cost_ff;
   logic [pgr_pkg::COST_BITS-1:0]  page_in_cost_ff;
   logic [pgr_pkg::COST_BITS-1:0]  page_out_cost_ff;

   // per-access context
   logic                          mode_ff;
   logic [pgr_pkg::DIR_BITS-1:0]  dir_ff;
   logic [pgr_pkg::TAB_BITS-1:0]  tab_ff;
   pgr_pkg::entry_type            old_ff;
   logic                          tab_alloc_ff;
   logic                          evicted_ff;
   logic [pgr_pkg::PAGE_BITS-1:0] vic_idx_ff;
   logic                          vic_dirty_ff;
   logic [pgr_pkg::STEP_BITS-1:0] step_ff, step_in;
   logic [pgr_pkg::COST_BITS-1:0] cost_sel;

   // running counters
   logic [pgr_pkg::FRAME_BITS-1:0] count_ff, count_in;
   logic [pgr_pkg::FRAME_BITS-1:0] peak_ff, peak_in;
   logic [pgr_pkg::COUNT_BITS-1:0] acc_ff;
   logic [pgr_pkg::COUNT_BITS-1:0] total_ff;

   // clearing pass and scan sequencing
   logic [pgr_pkg::PAGE_BITS-1:0] clr_idx_ff;
   logic [pgr_pkg::PAGE_BITS-1:0] scan_idx_ff;
   logic                          scan_issue_ff;
   logic                          scan_vld_ff;
   logic                          scan_last_ff;
   logic [pgr_pkg::PAGE_BITS-1:0] scan_pidx_ff;

   // memories
   logic                          dir_wr_en;
   logic [pgr_pkg::DIR_BITS-1:0]  dir_wr_addr;
   logic [0:0]                    dir_wr_data;
   logic [pgr_pkg::DIR_BITS-1:0]  dir_rd_addr;
   logic [0:0]                    dir_rd_data;
   logic                          pg_wr_en;
   logic [pgr_pkg::PAGE_BITS-1:0] pg_wr_addr;
   pgr_pkg::entry_type            pg_wr_data;
   logic [pgr_pkg::PAGE_BITS-1:0] pg_rd_addr;
   pgr_pkg::entry_type            pg_rd_data;

   pgr_pkg::scan_ctl_type scan_ctl;
   pgr_pkg::scan_res_type scan_res;

   // response registers
   logic                           rsp_valid_ff;
   logic                           rsp_tab_ff, rsp_pg_alloc_ff, rsp_pg_in_ff, rsp_evicted_ff;
   logic [pgr_pkg::DIR_BITS-1:0]   rsp_vdir_ff;
   logic [pgr_pkg::TAB_BITS-1:0]   rsp_vtab_ff;
   logic                           rsp_vdirty_ff;
   logic [pgr_pkg::STEP_BITS-1:0]  rsp_step_ff;
   logic [pgr_pkg::COUNT_BITS-1:0] rsp_total_ff;
   logic [pgr_pkg::FRAME_BITS-1:0] rsp_ws_ff, rsp_peak_ff;
   logic [pgr_pkg::COUNT_BITS-1:0] rsp_acc_ff;

   logic accept, full, clr_done, swap_in;
   logic [pgr_pkg::PAGE_BITS-1:0] cur_idx;

   assign busy    = (state_ff != S_IDLE);
   assign accept  = start && !busy;
   assign full    = (count_ff >= max_frames_ff);
   assign clr_done = (clr_idx_ff == {pgr_pkg::PAGE_BITS{1'b1}});
   assign swap_in = old_ff.alloc;
   assign cur_idx = {dir_ff, tab_ff};

   pgr_ram #(
      .ADDR_BITS (pgr_pkg::DIR_BITS),
      .DATA_BITS (1)
   ) u_dir_ram (
      .clock   (clock),
      .wr_en   (dir_wr_en),
      .wr_addr (dir_wr_addr),
      .wr_data (dir_wr_data),
      .rd_addr (dir_rd_addr),
      .rd_data (dir_rd_data)
   );

   pgr_ram #(
      .ADDR_BITS (pgr_pkg::PAGE_BITS),
      .DATA_BITS (pgr_pkg::ENTRY_BITS)
   ) u_page_ram (
      .clock   (clock),
      .wr_en   (pg_wr_en),
      .wr_addr (pg_wr_addr),
      .wr_data (pg_wr_data),
      .rd_addr (pg_rd_addr),
      .rd_data (pg_rd_data)
   );

   pgr_scan u_scan (
      .clock (clock),
      .ctl   (scan_ctl),
      .entry (pg_rd_data),
      .res   (scan_res)
   );

   assign scan_ctl.init  = (state_ff == S_CHECK) && full;
   assign scan_ctl.valid = scan_vld_ff;
   assign scan_ctl.idx   = scan_pidx_ff;

   assign dir_rd_addr = req_address[pgr_pkg::DIR_LSB +: pgr_pkg::DIR_BITS];
   assign pg_rd_addr  = (state_ff == S_SCAN) ? scan_idx_ff :
                        {req_address[pgr_pkg::DIR_LSB +: pgr_pkg::DIR_BITS],
                         req_address[pgr_pkg::TAB_LSB +: pgr_pkg::TAB_BITS]};

   // memory write selection
   always_comb begin
      dir_wr_en   = 1'b0;
      dir_wr_addr = dir_ff;
      dir_wr_data = 1'b1;
      pg_wr_en    = 1'b0;
      pg_wr_addr  = cur_idx;
      pg_wr_data  = '0;
      unique case (state_ff)
         S_CLEAR: begin
            dir_wr_en   = 1'b1;
            dir_wr_addr = clr_idx_ff[pgr_pkg::DIR_BITS-1:0];
            dir_wr_data = 1'b0;
            pg_wr_en    = 1'b1;
            pg_wr_addr  = clr_idx_ff;
         end
         S_LOOK: begin
            dir_wr_en = !dir_rd_data[0];
         end
         S_EVICT: begin
            pg_wr_en           = scan_res.found;
            pg_wr_addr         = scan_res.idx;
            pg_wr_data         = scan_res.entry;
            pg_wr_data.present = 1'b0;
         end
         S_FINISH: begin
            pg_wr_en            = 1'b1;
            pg_wr_data.alloc    = 1'b1;
            pg_wr_data.present  = 1'b1;
            pg_wr_data.dirty    = (old_ff.present && old_ff.dirty) || mode_ff;
            pg_wr_data.stamp    = acc_ff;
         end
         default: begin
         end
      endcase
   end

   // shared cost adder and working-set counter
   always_comb begin
      cost_sel = '0;
      count_in = count_ff;
      unique case (state_ff)
         S_LOOK: begin
            cost_sel = mem_cost_ff;
            if (!dir_rd_data[0]) begin
               count_in = count_ff + 1'b1;
            end
         end
         S_EVICT: begin
            if (scan_res.found) begin
               count_in = count_ff - 1'b1;
               if (scan_res.entry.dirty) begin
                  cost_sel = page_out_cost_ff;
               end
            end
         end
         S_PLACE: begin
            count_in = count_ff + 1'b1;
            if (swap_in) begin
               cost_sel = page_in_cost_ff;
            end
         end
         S_FINISH: begin
            cost_sel = mem_cost_ff;
         end
         default: begin
         end
      endcase
      step_in = step_ff + {{(pgr_pkg::STEP_BITS - pgr_pkg::COST_BITS){1'b0}}, cost_sel};
      peak_in = (count_in > peak_ff) ? count_in : peak_ff;
   end

   // sequencer
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE:   if (start) state_in = S_LOOK;
         S_CLEAR:  if (clr_done) state_in = S_IDLE;
         S_LOOK:   state_in = pg_rd_data.present ? S_FINISH : S_CHECK;
         S_CHECK:  state_in = full ? S_SCAN : S_PLACE;
         S_SCAN:   if (scan_last_ff) state_in = S_EVICT;
         S_EVICT:  state_in = S_PLACE;
         S_PLACE:  state_in = S_FINISH;
         S_FINISH: state_in = S_IDLE;
         default:  state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_CLEAR;
         clr_idx_ff    <= '0;
         scan_issue_ff <= 1'b0;
         scan_vld_ff   <= 1'b0;
         scan_last_ff  <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         count_ff      <= '0;
         peak_ff       <= '0;
         acc_ff        <= '0;
         total_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= (state_ff == S_FINISH);
         if (state_ff == S_CLEAR) begin
            clr_idx_ff <= clr_idx_ff + 1'b1;
         end
         if (state_ff == S_LOOK) begin
            acc_ff <= acc_ff + 1'b1;
         end
         count_ff <= count_in;
         peak_ff  <= peak_in;
         if (state_ff == S_FINISH) begin
            total_ff <= total_ff +
                        {{(pgr_pkg::COUNT_BITS - pgr_pkg::STEP_BITS){1'b0}}, step_in};
         end
         // scan address issue; read data follows in the next cycle
         if (scan_ctl.init) begin
            scan_issue_ff <= 1'b1;
         end else if (scan_issue_ff && (scan_idx_ff == {pgr_pkg::PAGE_BITS{1'b1}})) begin
            scan_issue_ff <= 1'b0;
         end
         scan_vld_ff  <= scan_issue_ff;
         scan_last_ff <= scan_issue_ff && (scan_idx_ff == {pgr_pkg::PAGE_BITS{1'b1}});
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_frames_ff    <= pgr_pkg::MAX_FRAMES_RST;
         mem_cost_ff      <= pgr_pkg::MEM_COST_RST;
         page_in_cost_ff  <= pgr_pkg::PAGE_IN_COST_RST;
         page_out_cost_ff <= pgr_pkg::PAGE_OUT_COST_RST;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            pgr_pkg::CSR_MAX_FRAMES:    max_frames_ff    <= csr_wdata;
            pgr_pkg::CSR_MEM_COST:      mem_cost_ff      <= csr_wdata[pgr_pkg::COST_BITS-1:0];
            pgr_pkg::CSR_PAGE_IN_COST:  page_in_cost_ff  <= csr_wdata[pgr_pkg::COST_BITS-1:0];
            pgr_pkg::CSR_PAGE_OUT_COST: page_out_cost_ff <= csr_wdata[pgr_pkg::COST_BITS-1:0];
            default: begin
            end
         endcase
      end
   end

   // per-access payload, no reset needed
   always_ff @(posedge clock) begin
      if (scan_ctl.init) begin
         scan_idx_ff <= '0;
      end else if (scan_issue_ff) begin
         scan_idx_ff <= scan_idx_ff + 1'b1;
      end
      scan_pidx_ff <= scan_idx_ff;
      step_ff      <= step_in;
      if (accept) begin
         mode_ff      <= req_mode;
         dir_ff       <= req_address[pgr_pkg::DIR_LSB +: pgr_pkg::DIR_BITS];
         tab_ff       <= req_address[pgr_pkg::TAB_LSB +: pgr_pkg::TAB_BITS];
         step_ff      <= '0;
         tab_alloc_ff <= 1'b0;
         evicted_ff   <= 1'b0;
         vic_idx_ff   <= '0;
         vic_dirty_ff <= 1'b0;
      end
      if (state_ff == S_LOOK) begin
         old_ff       <= pg_rd_data;
         tab_alloc_ff <= !dir_rd_data[0];
      end
      if ((state_ff == S_EVICT) && scan_res.found) begin
         evicted_ff   <= 1'b1;
         vic_idx_ff   <= scan_res.idx;
         vic_dirty_ff <= scan_res.entry.dirty;
      end
      if (state_ff == S_FINISH) begin
         rsp_tab_ff      <= tab_alloc_ff;
         rsp_pg_alloc_ff <= !old_ff.present && !old_ff.alloc;
         rsp_pg_in_ff    <= !old_ff.present && old_ff.alloc;
         rsp_evicted_ff  <= evicted_ff;
         rsp_vdir_ff     <= vic_idx_ff[pgr_pkg::PAGE_BITS-1 -: pgr_pkg::DIR_BITS];
         rsp_vtab_ff     <= vic_idx_ff[pgr_pkg::TAB_BITS-1:0];
         rsp_vdirty_ff   <= vic_dirty_ff;
         rsp_step_ff     <= step_in;
         rsp_total_ff    <= total_ff +
                            {{(pgr_pkg::COUNT_BITS - pgr_pkg::STEP_BITS){1'b0}}, step_in};
         rsp_ws_ff       <= count_ff;
         rsp_peak_ff     <= peak_ff;
         rsp_acc_ff      <= acc_ff;
      end
   end

   assign rsp_valid              = rsp_valid_ff;
   assign rsp_table_allocated    = rsp_tab_ff;
   assign rsp_page_allocated     = rsp_pg_alloc_ff;
   assign rsp_page_swapped_in    = rsp_pg_in_ff;
   assign rsp_evicted            = rsp_evicted_ff;
   assign rsp_victim_dir_index   = rsp_vdir_ff;
   assign rsp_victim_table_index = rsp_vtab_ff;
   assign rsp_victim_dirty       = rsp_vdirty_ff;
   assign rsp_cycles_added       = rsp_step_ff;
   assign rsp_total_cycles       = rsp_total_ff;
   assign rsp_working_set        = rsp_ws_ff;
   assign rsp_peak_working_set   = rsp_peak_ff;
   assign rsp_access_count       = rsp_acc_ff;

   a_rsp_after_finish: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> $past(state_ff == S_FINISH))
      else $error("result strobe without a finishing access");

   a_alloc_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_pg_alloc_ff && rsp_pg_in_ff))
      else $error("page both allocated and swapped in");

   a_peak_bound: assert property (@(posedge clock) disable iff (reset)
      peak_ff >= count_ff)
      else $error("working set above its recorded peak");

   a_no_victim: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_evicted_ff) |->
         (rsp_vdir_ff == '0 && rsp_vtab_ff == '0 && !rsp_vdirty_ff))
      else $error("victim fields set without an eviction");

   a_scan_last_in_scan: assert property (@(posedge clock) disable iff (reset)
      scan_last_ff |-> (state_ff == S_SCAN))
      else $error("scan end seen outside the scan");

endmodule

/* hdl/pgr_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module pgr_ram #(
   parameter int ADDR_BITS = 10,
   parameter int DATA_BITS = 1
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [ADDR_BITS-1:0] wr_addr,
   input  logic [DATA_BITS-1:0] wr_data,
   input  logic [ADDR_BITS-1:0] rd_addr,
   output logic [DATA_BITS-1:0] rd_data
);

   logic [DATA_BITS-1:0] mem_ff [2**ADDR_BITS];
   logic [DATA_BITS-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* hdl/pgr_scan.sv */
// Victim search unit: one stamp compare per cycle over streamed page entries.
// Depends on pgr_pkg.
module pgr_scan (
   input  logic                 clock,
   input  pgr_pkg::scan_ctl_type ctl,
   input  pgr_pkg::entry_type    entry,
   output pgr_pkg::scan_res_type res
);

   logic                         found_ff;
   logic [pgr_pkg::PAGE_BITS-1:0] idx_ff;
   pgr_pkg::entry_type           best_ff;
   logic                         take;

   // "<=" so that the last entry scanned wins a tie
   assign take = ctl.valid && entry.present && (entry.stamp <= best_ff.stamp);

   always_ff @(posedge clock) begin
      if (ctl.init) begin
         found_ff      <= 1'b0;
         idx_ff        <= '0;
         best_ff       <= '0;
         best_ff.stamp <= '1;
      end else if (take) begin
         found_ff <= 1'b1;
         idx_ff   <= ctl.idx;
         best_ff  <= entry;
      end
   end

   assign res.found = found_ff;
   assign res.idx   = idx_ff;
   assign res.entry = best_ff;

endmodule

/* tb/tb_two_level_page_table_lru_pager.sv */
// Self-checking testbench for two_level_page_table_lru_pager.
// Directed table plus random accesses, each scored against a local pager model.
// Depends on pgr_pkg and the block under hdl/.
module tb_two_level_page_table_lru_pager;
   import pgr_pkg::*;

   // every eviction scan walks all 2^20 entries, so scans are rationed
   localparam int SCAN_BUDGET = 8;
   localparam int PHASE_ITEMS = 30;
   localparam int QUIET_ITEMS = 20;
   localparam int CYCLE_LIMIT = 4 * (SCAN_BUDGET + 1) * ((1 << PAGE_BITS) + 16) + 200000;

   typedef struct packed {
      logic                  table_allocated;
      logic                  page_allocated;
      logic                  page_swapped_in;
      logic                  evicted;
      logic [DIR_BITS-1:0]   victim_dir;
      logic [TAB_BITS-1:0]   victim_tab;
      logic                  victim_dirty;
      logic [STEP_BITS-1:0]  cycles_added;
      logic [COUNT_BITS-1:0] total_cycles;
      logic [FRAME_BITS-1:0] working_set;
      logic [FRAME_BITS-1:0] peak_set;
      logic [COUNT_BITS-1:0] access_count;
   } pager_result_t;

   typedef enum {ROW_REGS, ROW_ACCESS} row_kind_e;

   typedef struct {
      row_kind_e             kind;
      logic [FRAME_BITS-1:0] frames;
      logic [COST_BITS-1:0]  mem_c;
      logic [COST_BITS-1:0]  pin_c;
      logic [COST_BITS-1:0]  pout_c;
      logic                  wr;
      logic [ADDR_BITS-1:0]  addr;
      bit                    typed;
      pager_result_t         want;
   } drill_row_t;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    start = 1'b0;
   logic                    busy;
   logic                    req_mode = 1'b0;
   logic [ADDR_BITS-1:0]    req_address = '0;
   logic                    csr_wr_en = 1'b0;
   logic [CSR_IDX_BITS-1:0] csr_index = '0;
   logic [CSR_DAT_BITS-1:0] csr_wdata = '0;
   logic                    rsp_valid;
   logic                    rsp_table_allocated;
   logic                    rsp_page_allocated;
   logic                    rsp_page_swapped_in;
   logic                    rsp_evicted;
   logic [DIR_BITS-1:0]     rsp_victim_dir_index;
   logic [TAB_BITS-1:0]     rsp_victim_table_index;
   logic                    rsp_victim_dirty;
   logic [STEP_BITS-1:0]    rsp_cycles_added;
   logic [COUNT_BITS-1:0]   rsp_total_cycles;
   logic [FRAME_BITS-1:0]   rsp_working_set;
   logic [FRAME_BITS-1:0]   rsp_peak_working_set;
   logic [COUNT_BITS-1:0]   rsp_access_count;

   two_level_page_table_lru_pager dut (
      .clock                  (clock),
      .reset                  (reset),
      .start                  (start),
      .busy                   (busy),
      .req_mode               (req_mode),
      .req_address            (req_address),
      .csr_wr_en              (csr_wr_en),
      .csr_index              (csr_index),
      .csr_wdata              (csr_wdata),
      .rsp_valid              (rsp_valid),
      .rsp_table_allocated    (rsp_table_allocated),
      .rsp_page_allocated     (rsp_page_allocated),
      .rsp_page_swapped_in    (rsp_page_swapped_in),
      .rsp_evicted            (rsp_evicted),
      .rsp_victim_dir_index   (rsp_victim_dir_index),
      .rsp_victim_table_index (rsp_victim_table_index),
      .rsp_victim_dirty       (rsp_victim_dirty),
      .rsp_cycles_added       (rsp_cycles_added),
      .rsp_total_cycles       (rsp_total_cycles),
      .rsp_working_set        (rsp_working_set),
      .rsp_peak_working_set   (rsp_peak_working_set),
      .rsp_access_count       (rsp_access_count)
   );

   always #5 clock = ~clock;

   // local pager state and register mirror
   bit                    dir_seen [1 << DIR_BITS];
   entry_type             page_tab [int];
   logic [FRAME_BITS-1:0] resident_r = '0;
   logic [FRAME_BITS-1:0] peak_r = '0;
   logic [COUNT_BITS-1:0] acc_count_r = '0;
   logic [COUNT_BITS-1:0] total_r = '0;
   logic [FRAME_BITS-1:0] frames_r = MAX_FRAMES_RST;
   logic [COST_BITS-1:0]  mem_r = MEM_COST_RST;
   logic [COST_BITS-1:0]  pin_r = PAGE_IN_COST_RST;
   logic [COST_BITS-1:0]  pout_r = PAGE_OUT_COST_RST;

   pager_result_t pending_walks [$];
   drill_row_t    drill [$];
   int            mismatches = 0;
   int            items_sent = 0;
   int            scans_run = 0;
   int            evictions_seen = 0;
   int            swapins_seen = 0;
   int            cycle_count = 0;

   function automatic void grow_resident();
      resident_r = resident_r + 1'b1;
      if (resident_r > peak_r) peak_r = resident_r;
   endfunction

   function automatic bit would_scan(input logic [ADDR_BITS-1:0] addr);
      logic [FRAME_BITS-1:0] rc;
      int                    idx;
      idx = addr[DIR_LSB+DIR_BITS-1:TAB_LSB];
      rc = resident_r + (dir_seen[addr[DIR_LSB+DIR_BITS-1:DIR_LSB]] ? 1'b0 : 1'b1);
      if (page_tab.exists(idx) && page_tab[idx].present) return 1'b0;
      return rc >= frames_r;
   endfunction

   function automatic pager_result_t page_walk(input logic wr, input logic [ADDR_BITS-1:0] addr);
      pager_result_t        r;
      logic [DIR_BITS-1:0]  d;
      int                   idx;
      logic [31:0]          steps;
      logic [STAMP_BITS-1:0] best;
      logic [PAGE_BITS-1:0] best_idx;
      bit                   found;
      entry_type            e;
      r = '0;
      d = addr[DIR_LSB+DIR_BITS-1:DIR_LSB];
      idx = addr[DIR_LSB+DIR_BITS-1:TAB_LSB];
      steps = 0;
      acc_count_r = acc_count_r + 1'b1;
      if (!dir_seen[d]) begin
         dir_seen[d] = 1'b1;
         r.table_allocated = 1'b1;
         grow_resident();
      end
      steps += mem_r;
      e = page_tab.exists(idx) ? page_tab[idx] : '0;
      if (!e.present) begin
         if (resident_r >= frames_r) begin
            // LRU scan in ascending page order; ties go to the later entry
            scans_run++;
            best = '1;
            best_idx = '0;
            found = 1'b0;
            foreach (page_tab[i]) begin
               if (page_tab[i].present && page_tab[i].stamp <= best) begin
                  best = page_tab[i].stamp;
                  best_idx = i;
                  found = 1'b1;
               end
            end
            if (found) begin
               evictions_seen++;
               r.evicted = 1'b1;
               r.victim_dir = best_idx[PAGE_BITS-1:TAB_BITS];
               r.victim_tab = best_idx[TAB_BITS-1:0];
               r.victim_dirty = page_tab[best_idx].dirty;
               page_tab[best_idx].present = 1'b0;
               resident_r = resident_r - 1'b1;
               if (r.victim_dirty) steps += pout_r;
            end
         end
         if (!e.alloc) begin
            r.page_allocated = 1'b1;
         end else begin
            r.page_swapped_in = 1'b1;
            swapins_seen++;
            steps += pin_r;
         end
         e.alloc = 1'b1;
         e.present = 1'b1;
         e.dirty = 1'b0;
         grow_resident();
      end
      steps += mem_r;
      e.stamp = acc_count_r;
      if (wr) e.dirty = 1'b1;
      page_tab[idx] = e;
      total_r = total_r + steps;
      r.cycles_added = steps[STEP_BITS-1:0];
      r.total_cycles = total_r;
      r.working_set = resident_r;
      r.peak_set = peak_r;
      r.access_count = acc_count_r;
      return r;
   endfunction

   function automatic pager_result_t outcome(
      input logic tab, pg, sw, ev,
      input logic [DIR_BITS-1:0] vd, input logic [TAB_BITS-1:0] vt, input logic vdirty,
      input logic [STEP_BITS-1:0] cyc, input logic [COUNT_BITS-1:0] tot,
      input logic [FRAME_BITS-1:0] ws, pk, input logic [COUNT_BITS-1:0] cnt);
      pager_result_t r;
      r = '{tab, pg, sw, ev, vd, vt, vdirty, cyc, tot, ws, pk, cnt};
      return r;
   endfunction

   function automatic drill_row_t regs_row(input logic [FRAME_BITS-1:0] frames,
                                           input logic [COST_BITS-1:0] mem_c, pin_c, pout_c);
      drill_row_t r;
      r.kind = ROW_REGS;
      r.frames = frames;
      r.mem_c = mem_c;
      r.pin_c = pin_c;
      r.pout_c = pout_c;
      r.wr = 1'b0;
      r.addr = '0;
      r.typed = 1'b0;
      r.want = '0;
      return r;
   endfunction

   function automatic drill_row_t typed_row(input logic wr, input logic [ADDR_BITS-1:0] addr,
                                            input bit typed, input pager_result_t want);
      drill_row_t r;
      r = regs_row('0, '0, '0, '0);
      r.kind = ROW_ACCESS;
      r.wr = wr;
      r.addr = addr;
      r.typed = typed;
      r.want = want;
      return r;
   endfunction

   function automatic drill_row_t access_row(input logic wr, input logic [ADDR_BITS-1:0] addr);
      return typed_row(wr, addr, 1'b0, '0);
   endfunction

   function automatic logic [COST_BITS-1:0] rand_cost();
      case ($urandom_range(0, 3))
         0: return '0;
         1: return '1;
         default: return $urandom_range(0, 65535);
      endcase
   endfunction

   // small pools of directory and table indexes so hits and swap-ins recur
   function automatic logic [ADDR_BITS-1:0] random_address();
      logic [DIR_BITS-1:0] d;
      logic [TAB_BITS-1:0] t;
      logic [TAB_LSB-1:0]  offs;
      offs = $urandom_range(0, 4095);
      if ($urandom_range(0, 9) == 0) return $urandom();
      case ($urandom_range(0, 4))
         0: d = '0;
         1: d = 10'd1;
         2: d = '1;
         3: d = 10'h200;
         default: d = $urandom_range(2, 5);
      endcase
      case ($urandom_range(0, 4))
         0: t = '0;
         1: t = '1;
         default: t = $urandom_range(1, 6);
      endcase
      return {d, t, offs};
   endfunction

   function automatic void check_field(input string name, input logic [31:0] want,
                                       input logic [31:0] got);
      if (want !== got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         mismatches++;
      end
   endfunction

   task automatic wait_drained();
      start <= 1'b0;
      while (pending_walks.size() != 0 || busy) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_BITS-1:0] idx,
                            input logic [CSR_DAT_BITS-1:0] data);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      case (idx)
         CSR_MAX_FRAMES:    frames_r = data;
         CSR_MEM_COST:      mem_r = data[COST_BITS-1:0];
         CSR_PAGE_IN_COST:  pin_r = data[COST_BITS-1:0];
         CSR_PAGE_OUT_COST: pout_r = data[COST_BITS-1:0];
         default: ;
      endcase
   endtask

   task automatic program_regs(input logic [FRAME_BITS-1:0] frames,
                               input logic [COST_BITS-1:0] mem_c, pin_c, pout_c);
      logic [CSR_DAT_BITS-COST_BITS-1:0] junk;
      wait_drained();
      // unused upper bits of the cost registers carry noise
      junk = $urandom_range(0, 31);
      write_reg(CSR_MAX_FRAMES, frames);
      write_reg(CSR_MEM_COST, {junk, mem_c});
      write_reg(CSR_PAGE_IN_COST, {~junk, pin_c});
      write_reg(CSR_PAGE_OUT_COST, {junk, pout_c});
      csr_wr_en <= 1'b0;
   endtask

   task automatic send_access(input logic wr, input logic [ADDR_BITS-1:0] addr,
                              input bit typed, input pager_result_t want);
      pager_result_t got;
      start <= 1'b1;
      req_mode <= wr;
      req_address <= addr;
      do @(posedge clock); while (busy);
      got = page_walk(wr, addr);
      pending_walks.push_back(typed ? want : got);
      items_sent++;
   endtask

   always @(posedge clock) begin : rsp_monitor
      pager_result_t w;
      if (!reset && rsp_valid) begin
         if (pending_walks.size() == 0) begin
            $error("result transfer with no access outstanding");
            mismatches++;
         end else begin
            w = pending_walks.pop_front();
            check_field("table_allocated", w.table_allocated, rsp_table_allocated);
            check_field("page_allocated", w.page_allocated, rsp_page_allocated);
            check_field("page_swapped_in", w.page_swapped_in, rsp_page_swapped_in);
            check_field("evicted", w.evicted, rsp_evicted);
            check_field("victim_dir_index", w.victim_dir, rsp_victim_dir_index);
            check_field("victim_table_index", w.victim_tab, rsp_victim_table_index);
            check_field("victim_dirty", w.victim_dirty, rsp_victim_dirty);
            check_field("cycles_added", w.cycles_added, rsp_cycles_added);
            check_field("total_cycles", w.total_cycles, rsp_total_cycles);
            check_field("working_set", w.working_set, rsp_working_set);
            check_field("peak_working_set", w.peak_set, rsp_peak_working_set);
            check_field("access_count", w.access_count, rsp_access_count);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("simulation failed");
         $finish;
      end
   end

   initial begin : stimulus
      logic [ADDR_BITS-1:0] addr;
      logic                 wr;
      logic [PAGE_BITS-1:0] last_page;

      // max_frames zero with only a table resident: full set, nothing to evict
      drill.push_back(regs_row(21'd0, MEM_COST_RST, PAGE_IN_COST_RST, PAGE_OUT_COST_RST));
      drill.push_back(typed_row(1'b0, 32'h0000_0000, 1'b1,
                                outcome(1, 1, 0, 0, 0, 0, 0, 20, 20, 2, 2, 1)));
      drill.push_back(regs_row(MAX_FRAMES_RST, MEM_COST_RST, PAGE_IN_COST_RST,
                               PAGE_OUT_COST_RST));
      drill.push_back(typed_row(1'b1, 32'hFFFF_FFFF, 1'b1,
                                outcome(1, 1, 0, 0, 0, 0, 0, 20, 40, 4, 4, 2)));
      drill.push_back(typed_row(1'b0, 32'h0000_0FFF, 1'b1,
                                outcome(0, 0, 0, 0, 0, 0, 0, 20, 60, 4, 4, 3)));
      // full set: new page evicts the dirty top page
      drill.push_back(regs_row(21'd4, MEM_COST_RST, PAGE_IN_COST_RST, PAGE_OUT_COST_RST));
      drill.push_back(typed_row(1'b1, 32'h0000_1000, 1'b1,
                                outcome(0, 1, 0, 1, 1023, 1023, 1, 5020, 5080, 4, 4, 4)));
      drill.push_back(access_row(1'b1, 32'hFFFF_F000));   // swap-in with clean victim
      drill.push_back(regs_row(21'h10_0000, '1, '1, '1));
      drill.push_back(access_row(1'b0, 32'h0000_0000));   // swap-in, room left
      drill.push_back(access_row(1'b1, 32'h1234_5678));
      drill.push_back(access_row(1'b0, 32'h1234_5678));
      drill.push_back(regs_row(21'd7, '1, '1, '1));
      drill.push_back(access_row(1'b1, 32'h8000_0000));   // new table, then dirty eviction
      drill.push_back(access_row(1'b0, 32'h0000_1ABC));   // swap-in plus dirty write-back
      drill.push_back(regs_row(21'd0, '0, '0, '0));
      drill.push_back(access_row(1'b0, 32'h8000_0FFF));
      drill.push_back(access_row(1'b1, 32'h0000_0123));

      repeat (7) @(posedge clock);
      reset <= 1'b0;
      // let the clearing pass raise busy before looking at it
      repeat (2) @(posedge clock);

      foreach (drill[k]) begin
         if (drill[k].kind == ROW_REGS)
            program_regs(drill[k].frames, drill[k].mem_c, drill[k].pin_c, drill[k].pout_c);
         else
            send_access(drill[k].wr, drill[k].addr, drill[k].typed, drill[k].want);
      end
      last_page = 20'h00000;

      for (int ph = 0; ph < 3; ph++) begin
         case (ph)
            0: program_regs(21'h10_0000 - $urandom_range(0, 1000), rand_cost(), rand_cost(),
                            rand_cost());
            1: program_regs(21'd1, rand_cost(), rand_cost(), rand_cost());
            default: program_regs(21'h0F_FFFF, rand_cost(), rand_cost(), rand_cost());
         endcase
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            addr = random_address();
            wr = $urandom_range(0, 1);
            // out of scan budget: touch the last page instead, which is resident
            if (would_scan(addr) && scans_run >= SCAN_BUDGET)
               addr = {last_page, addr[TAB_LSB-1:0]};
            send_access(wr, addr, 1'b0, '0);
            last_page = addr[ADDR_BITS-1:TAB_LSB];
            if (!(ph == 2 && n >= PHASE_ITEMS - QUIET_ITEMS)) begin
               if ($urandom_range(0, 11) == 0) begin
                  wait_drained();
               end else if ($urandom_range(0, 2) == 0) begin
                  start <= 1'b0;
                  repeat ($urandom_range(1, 8)) @(posedge clock);
               end
            end
         end
      end

      wait_drained();
      repeat (8) @(posedge clock);

      $display("covered %0d accesses: %0d eviction scans, %0d evictions, %0d swap-ins",
               items_sent, scans_run, evictions_seen, swapins_seen);
      $display("max_frames swept from 0 to 2^20, costs from 0 to 65535");
      if (mismatches == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule
